/* rtl/rob_pkg.sv */
// ----------------------------------------------------------------------------
// rob_pkg: shared types, constants and float helpers
// Widths, state codes and IEEE single compare functions for the octant binner.
// ----------------------------------------------------------------------------
package rob_pkg;

  localparam int NUM_BINS        = 8;
  localparam int BIN_W           = 3;
  localparam int FP_W            = 32;
  localparam int ID_W            = 16;
  localparam int BSIZE_W         = 7;
  localparam int DEF_BIN_DEPTH   = 64;
  localparam int DEF_RAY_ID_BITS = 16;

  localparam logic ACT_SUBMIT = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             drop;
    logic [BIN_W-1:0] bin;
  } class_t;

  function automatic logic fp_is_nan(input logic [FP_W-1:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  function automatic logic fp_is_neg(input logic [FP_W-1:0] v);
    return v[31] && (v[30:0] != 31'd0) && !fp_is_nan(v);
  endfunction

  function automatic logic fp_gt(input logic [FP_W-1:0] a, input logic [FP_W-1:0] b);
    logic res;
    res = 1'b0;
    if (fp_is_nan(a) || fp_is_nan(b)) begin
      res = 1'b0;
    end else if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
      res = 1'b0;
    end else if (!a[31] && b[31]) begin
      res = 1'b1;
    end else if (a[31] && !b[31]) begin
      res = 1'b0;
    end else if (!a[31]) begin
      res = a[30:0] > b[30:0];
    end else begin
      res = a[30:0] < b[30:0];
    end
    return res;
  endfunction

endpackage

/* rtl/rob_if.sv */
// ----------------------------------------------------------------------------
// rob_if: stream channels of the octant binner
// Valid/ready channels for ray transactions in and batch results out.
// ----------------------------------------------------------------------------
interface rob_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [rob_pkg::ID_W-1:0]   ray_id;
  logic [rob_pkg::FP_W-1:0]   tnear;
  logic [rob_pkg::FP_W-1:0]   tfar;
  logic [rob_pkg::FP_W-1:0]   dir_x;
  logic [rob_pkg::FP_W-1:0]   dir_y;
  logic [rob_pkg::FP_W-1:0]   dir_z;
  logic [rob_pkg::FP_W-1:0]   geom_id;

  modport source (output valid, action, ray_id, tnear, tfar, dir_x, dir_y, dir_z, geom_id,
                  input ready);
  modport sink   (input valid, action, ray_id, tnear, tfar, dir_x, dir_y, dir_z, geom_id,
                  output ready);
endinterface

interface rob_out_if;
  logic                        valid;
  logic                        ready;
  logic [rob_pkg::BIN_W-1:0]   octant;
  logic [rob_pkg::ID_W-1:0]    out_ray_id;
  logic [rob_pkg::BSIZE_W-1:0] batch_size;
  logic                        last;
  logic                        more_pending;

  modport source (output valid, octant, out_ray_id, batch_size, last, more_pending,
                  input ready);
  modport sink   (input valid, octant, out_ray_id, batch_size, last, more_pending,
                  output ready);
endinterface

/* rtl/rob_ram.sv */
// ----------------------------------------------------------------------------
// rob_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rob_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/rob_classify.sv */
// ----------------------------------------------------------------------------
// rob_classify: ray drop test and octant selection
// Applies the distance and occlusion drop rules and forms the octant code.
// ----------------------------------------------------------------------------
module rob_classify (
  input  logic [rob_pkg::FP_W-1:0] tnear,
  input  logic [rob_pkg::FP_W-1:0] tfar,
  input  logic [rob_pkg::FP_W-1:0] dir_x,
  input  logic [rob_pkg::FP_W-1:0] dir_y,
  input  logic [rob_pkg::FP_W-1:0] dir_z,
  input  logic [rob_pkg::FP_W-1:0] geom_id,
  input  logic                     occl,
  output rob_pkg::class_t          cls
);

  always_comb begin
    cls.drop = rob_pkg::fp_gt(tnear, tfar) || (occl && (geom_id == '0));
    cls.bin  = {rob_pkg::fp_is_neg(dir_z), rob_pkg::fp_is_neg(dir_y),
                rob_pkg::fp_is_neg(dir_x)};
  end

endmodule

/* rtl/ray_octant_binner.sv */
// ----------------------------------------------------------------------------
// ray_octant_binner: sort rays into eight direction octant bins
// A submit that does not fill a bin is stored in ST_IDLE; a batch drains one
// result at a time via ST_READ (RAM read), ST_WAIT (data capture) and ST_OUT
// (output transaction). Throughput: 1 transaction per cycle in ST_IDLE, the
// only state taking input. Reset clears bin counts, mode and control; no clearing pass.
// ----------------------------------------------------------------------------
module ray_octant_binner #(
  parameter int BIN_DEPTH   = rob_pkg::DEF_BIN_DEPTH,
  parameter int RAY_ID_BITS = rob_pkg::DEF_RAY_ID_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  rob_in_if.sink       in_ch,
  rob_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic         cfg_wdata
);

  localparam int DEPTH  = rob_pkg::NUM_BINS * BIN_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(BIN_DEPTH + 1);
  localparam int IDX_W  = $clog2(BIN_DEPTH);
  localparam int BW     = rob_pkg::BIN_W;

  rob_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r [rob_pkg::NUM_BINS];
  logic [CNT_W-1:0] cnt_nxt [rob_pkg::NUM_BINS];
  logic             occl_r;
  logic [BW-1:0]    ebin_r, ebin_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             pend_r, pend_nxt;

  logic [BW-1:0]              oct_r, oct_nxt;
  logic [rob_pkg::ID_W-1:0]   rid_r, rid_nxt;
  logic [rob_pkg::BSIZE_W-1:0] bsz_r, bsz_nxt;
  logic                       last_r, last_nxt;
  logic                       mp_r, mp_nxt;

  rob_pkg::class_t  cls;
  logic             we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic             re;
  logic [RAY_ID_BITS-1:0] rdata;
  logic             any_ne;
  logic [BW-1:0]    low_bin;
  logic             accept;

  rob_classify u_cls (
    .tnear   (in_ch.tnear),
    .tfar    (in_ch.tfar),
    .dir_x   (in_ch.dir_x),
    .dir_y   (in_ch.dir_y),
    .dir_z   (in_ch.dir_z),
    .geom_id (in_ch.geom_id),
    .occl    (occl_r),
    .cls     (cls)
  );

  rob_ram #(.WIDTH(RAY_ID_BITS), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (RAY_ID_BITS'(in_ch.ray_id)),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  function automatic logic others_ne(input logic [CNT_W-1:0] c [rob_pkg::NUM_BINS],
                                     input logic [BW-1:0] b);
    logic r;
    r = 1'b0;
    for (int i = 0; i < rob_pkg::NUM_BINS; i++) begin
      if (BW'(i) != b && c[i] != '0) r = 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    any_ne  = 1'b0;
    low_bin = '0;
    for (int i = rob_pkg::NUM_BINS - 1; i >= 0; i--) begin
      if (cnt_r[i] != '0) begin
        any_ne  = 1'b1;
        low_bin = BW'(i);
      end
    end
  end

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == rob_pkg::ST_IDLE);
  assign out_ch.valid = (state_r == rob_pkg::ST_OUT);
  assign out_ch.octant       = oct_r;
  assign out_ch.out_ray_id   = rid_r;
  assign out_ch.batch_size   = bsz_r;
  assign out_ch.last         = last_r;
  assign out_ch.more_pending = mp_r;

  assign waddr = ADDR_W'(cls.bin) * ADDR_W'(BIN_DEPTH) + ADDR_W'(cnt_r[cls.bin]);
  assign raddr = ADDR_W'(ebin_r) * ADDR_W'(BIN_DEPTH) + ADDR_W'(k_r);
  assign we    = accept && (in_ch.action == rob_pkg::ACT_SUBMIT) && !cls.drop;
  assign re    = (state_r == rob_pkg::ST_READ);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ebin_nxt  = ebin_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    pend_nxt  = pend_r;
    oct_nxt   = oct_r;
    rid_nxt   = rid_r;
    bsz_nxt   = bsz_r;
    last_nxt  = last_r;
    mp_nxt    = mp_r;
    case (state_r)
      rob_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_ch.action == rob_pkg::ACT_FLUSH) begin
            if (any_ne) begin
              ebin_nxt         = low_bin;
              n_nxt            = cnt_r[low_bin];
              pend_nxt         = others_ne(cnt_r, low_bin);
              cnt_nxt[low_bin] = '0;
              k_nxt            = '0;
              state_nxt        = rob_pkg::ST_READ;
            end else begin
              oct_nxt   = '0;
              rid_nxt   = '0;
              bsz_nxt   = '0;
              last_nxt  = 1'b1;
              mp_nxt    = 1'b0;
              state_nxt = rob_pkg::ST_OUT;
            end
          end else if (!cls.drop) begin
            if (cnt_r[cls.bin] == CNT_W'(BIN_DEPTH - 1)) begin
              ebin_nxt         = cls.bin;
              n_nxt            = CNT_W'(BIN_DEPTH);
              pend_nxt         = others_ne(cnt_r, cls.bin);
              cnt_nxt[cls.bin] = '0;
              k_nxt            = '0;
              state_nxt        = rob_pkg::ST_READ;
            end else begin
              cnt_nxt[cls.bin] = cnt_r[cls.bin] + 1'b1;
            end
          end
        end
      end
      rob_pkg::ST_READ: begin
        state_nxt = rob_pkg::ST_WAIT;
      end
      rob_pkg::ST_WAIT: begin
        oct_nxt   = ebin_r;
        rid_nxt   = rob_pkg::ID_W'(rdata);
        bsz_nxt   = rob_pkg::BSIZE_W'(n_r);
        last_nxt  = (CNT_W'(k_r) == n_r - 1'b1);
        mp_nxt    = pend_r;
        state_nxt = rob_pkg::ST_OUT;
      end
      rob_pkg::ST_OUT: begin
        if (out_ch.ready) begin
          if (last_r) begin
            state_nxt = rob_pkg::ST_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = rob_pkg::ST_READ;
          end
        end
      end
      default: state_nxt = rob_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rob_pkg::ST_IDLE;
      occl_r  <= 1'b0;
      for (int i = 0; i < rob_pkg::NUM_BINS; i++) cnt_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) occl_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    ebin_r <= ebin_nxt;
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    pend_r <= pend_nxt;
    oct_r  <= oct_nxt;
    rid_r  <= rid_nxt;
    bsz_r  <= bsz_nxt;
    last_r <= last_nxt;
    mp_r   <= mp_nxt;
  end

  a_wait_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rob_pkg::ST_WAIT |-> $past(state_r) == rob_pkg::ST_READ)
    else $error("data capture without a preceding read");

  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.batch_size == '0 |-> out_ch.last && !out_ch.more_pending
      && out_ch.octant == '0)
    else $error("malformed empty marker");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> state_r == rob_pkg::ST_IDLE)
    else $error("store written during drain");

  for (genvar g = 0; g < rob_pkg::NUM_BINS; g++) begin : g_chk
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
      cnt_r[g] < CNT_W'(BIN_DEPTH))
      else $error("bin count reached depth without emit");
  end

endmodule

/* test/rob_tb_if.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rob_tb_if: testbench-side notes for the octant binner channels
// The channel interfaces come from the RTL; this file holds the shared
// transaction type used by the checker.
// ----------------------------------------------------------------------------
package rob_tb_pkg;
  import rob_pkg::*;

  typedef struct packed {
    logic [BIN_W-1:0]   octant;
    logic [ID_W-1:0]    ray_id;
    logic [BSIZE_W-1:0] batch_size;
    logic               last;
    logic               more_pending;
  } batch_beat_t;
endpackage

/* test/rob_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rob_checker: octant batch predictor and comparator
// Watches both channels, bins accepted rays in its own model and compares
// each emitted batch beat with the oldest predicted one.
// ----------------------------------------------------------------------------
module rob_checker
  import rob_pkg::*;
  import rob_tb_pkg::*;
#(
  parameter int DEPTH = DEF_BIN_DEPTH
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   cfg_we,
  input  logic   cfg_wdata,
  rob_in_if      in_ch,
  rob_out_if     out_ch,
  output int     fail_count,
  output int     pending_beats,
  output int     beats_seen
);

  logic [ID_W-1:0] bin_ids [NUM_BINS][DEPTH];
  int              bin_fill [NUM_BINS];
  logic            occl_mode;
  batch_beat_t     beat_q [$];

  function automatic logic is_nan(logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 0);
  endfunction

  function automatic logic below_zero(logic [31:0] v);
    return v[31] && (v[30:0] != 0) && !is_nan(v);
  endfunction

  function automatic logic greater(logic [31:0] a, logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if (a[30:0] == 0 && b[30:0] == 0) return 1'b0;
    if (a[31] != b[31]) return b[31];
    if (!a[31]) return a[30:0] > b[30:0];
    return a[30:0] < b[30:0];
  endfunction

  task automatic emit_batch(int bn);
    int n;
    logic others;
    batch_beat_t b;
    n = bin_fill[bn];
    bin_fill[bn] = 0;
    others = 1'b0;
    for (int i = 0; i < NUM_BINS; i++)
      if (bin_fill[i] != 0) others = 1'b1;
    for (int k = 0; k < n; k++) begin
      b.octant = bn[BIN_W-1:0];
      b.ray_id = bin_ids[bn][k];
      b.batch_size = n[BSIZE_W-1:0];
      b.last = (k == n - 1);
      b.more_pending = others;
      beat_q.push_back(b);
    end
  endtask

  task automatic bin_ray();
    int bn;
    if (in_ch.action == ACT_FLUSH) begin
      for (int i = 0; i < NUM_BINS; i++)
        if (bin_fill[i] != 0) begin
          emit_batch(i);
          return;
        end
      beat_q.push_back('{octant: '0, ray_id: '0, batch_size: '0, last: 1'b1,
                         more_pending: 1'b0});
      return;
    end
    if (greater(in_ch.tnear, in_ch.tfar)) return;
    if (occl_mode && in_ch.geom_id == 0) return;
    bn = {below_zero(in_ch.dir_z), below_zero(in_ch.dir_y), below_zero(in_ch.dir_x)};
    bin_ids[bn][bin_fill[bn]] = in_ch.ray_id;
    bin_fill[bn]++;
    if (bin_fill[bn] >= DEPTH) emit_batch(bn);
  endtask

  always @(posedge clk) begin
    batch_beat_t exp_b, got;
    if (!rst_n) begin
      occl_mode <= 1'b0;
      for (int i = 0; i < NUM_BINS; i++) bin_fill[i] = 0;
      beat_q.delete();
      fail_count <= 0;
      beats_seen <= 0;
    end else begin
      if (cfg_we) occl_mode <= cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.octant, out_ch.out_ray_id, out_ch.batch_size, out_ch.last,
                out_ch.more_pending};
        beats_seen <= beats_seen + 1;
        if (beat_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected transaction %p", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_b = beat_q.pop_front();
          if (got !== exp_b) begin
            if (fail_count < 10) $display("exp %p got %p", exp_b, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) bin_ray();
    end
    pending_beats <= beat_q.size();
  end

endmodule

/* test/tb_ray_octant_binner.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ray_octant_binner: stream test of the octant binner
// Drives directed and random ray/flush transactions with random gaps and
// output stalls in both modes; a checker predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb_ray_octant_binner;
  import rob_pkg::*;

  localparam int  LIMIT = 1500000;
  localparam int  DEPTH = DEF_BIN_DEPTH;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  int   fails;
  int   pending;
  int   beats;
  int   cycles = 0;
  int   sent;
  logic stall_on;

  rob_in_if  in_ch ();
  rob_out_if out_ch ();

  ray_octant_binner dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  rob_checker #(.DEPTH(DEPTH)) chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch), .fail_count(fails),
    .pending_beats(pending), .beats_seen(beats)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // random output stalls before each transaction while stall_on is set
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = stall_on ? $urandom_range(0, 16) : 0;
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk iff out_ch.valid);
    end
  end

  function automatic logic [31:0] rand_dir();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'hFFC0_0001;
      3: return 32'h7F80_0000;
      4: return 32'hFF80_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_dist();
    case ($urandom_range(0, 5))
      0: return 32'h7FC0_0000;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return {1'b0, 8'($urandom_range(100, 140)), 23'($urandom())};
    endcase
  endfunction

  task automatic send(logic act, logic [15:0] id, logic [31:0] tn, logic [31:0] tf,
                      logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                      logic [31:0] gid, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.ray_id  <= id;
    in_ch.tnear   <= tn;
    in_ch.tfar    <= tf;
    in_ch.dir_x   <= dx;
    in_ch.dir_y   <= dy;
    in_ch.dir_z   <= dz;
    in_ch.geom_id <= gid;
    @(posedge clk iff in_ch.ready);
    sent++;
  endtask

  task automatic send_ray(logic [31:0] tn, logic [31:0] tf, logic [31:0] dx,
                          logic [31:0] dy, logic [31:0] dz, logic [31:0] gid);
    send(ACT_SUBMIT, 16'($urandom()), tn, tf, dx, dy, dz, gid, 1'b0);
  endtask

  task automatic drain_and_set(logic mode);
    int lim;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    lim = 0;
    while (pending != 0 && lim < 200000) begin
      @(posedge clk);
      lim++;
    end
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_phase(int n, bit gaps);
    logic [15:0] id;
    for (int i = 0; i < n; i++) begin
      id = 16'($urandom());
      if ($urandom_range(0, 19) == 0)
        send(ACT_FLUSH, id, $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), gaps);
      else
        send(ACT_SUBMIT, id, rand_dist(), rand_dist(), rand_dir(), rand_dir(),
             rand_dir(), ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom(), gaps);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    sent = 0;
    stall_on = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_SUBMIT;
    in_ch.ray_id = '0;
    in_ch.tnear = '0;
    in_ch.tfar = '0;
    in_ch.dir_x = '0;
    in_ch.dir_y = '0;
    in_ch.dir_z = '0;
    in_ch.geom_id = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty flush, signed zeros, NaN, drops, extremes
    send(ACT_FLUSH, '0, '0, '0, '0, '0, '0, '0, 1'b0);
    send(ACT_SUBMIT, 16'hFFFF, 32'h0, 32'h7F80_0000, 32'h8000_0000, 32'hFFC0_0001,
         32'hBF80_0000, 32'hFFFF_FFFF, 1'b0);
    send(ACT_SUBMIT, 16'h0000, 32'h7FC0_0000, 32'h0, 32'hBF80_0000, 32'hBF80_0000,
         32'hBF80_0000, 32'h0, 1'b0);
    send_ray(32'h4000_0000, 32'h3F80_0000, 32'h0, 32'h0, 32'h0, 32'h1);
    send_ray(32'h8000_0000, 32'h0000_0000, 32'hFF7F_FFFF, 32'h0, 32'h0, 32'h1);
    send_ray(32'hBF80_0000, 32'hC000_0000, 32'h0, 32'h0, 32'h0, 32'h1);
    send_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFF, 32'h0, 32'h1);
    for (int i = 0; i < 9; i++)
      send(ACT_FLUSH, 16'hFFFF, '1, '1, '1, '1, '1, '1, 1'b0);
    // full bin back to back
    for (int i = 0; i < DEPTH; i++)
      send_ray(32'h0, 32'h3F80_0000, 32'hBF80_0000, 32'h0, 32'h0, 32'h5);

    stall_on = 1'b1;
    random_phase(50, 1'b1);
    drain_and_set(1'b1);
    send_ray(32'h0, 32'h3F80_0000, 32'h0, 32'h0, 32'h0, 32'h0);
    send(ACT_FLUSH, '0, '0, '0, '0, '0, '0, '0, 1'b0);
    stall_on = 1'b0;
    random_phase(40, 1'b0);
    stall_on = 1'b1;
    random_phase(50, 1'b1);
    drain_and_set(1'b0);
    random_phase(40, 1'b1);
    for (int i = 0; i < 9; i++)
      send(ACT_FLUSH, '0, '0, '0, '0, '0, '0, '0, 1'b1);

    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d transactions in both modes, %0d result transactions checked.",
             sent, beats);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
